// ===== rtl/core/usb_pd_protocol_tx_layer_assert.svh =====
// assertion macros for the usb pd protocol tx layer
`ifndef USB_PD_PROTOCOL_TX_LAYER_ASSERT_SVH
`define USB_PD_PROTOCOL_TX_LAYER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UPDTX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define UPDTX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/updtx_pkg.sv =====
// types and constants shared by the usb pd protocol tx layer
package updtx_pkg;

   // event codes
   localparam logic [2:0] OP_RESET       = 3'd0;
   localparam logic [2:0] OP_DISCARD     = 3'd1;
   localparam logic [2:0] OP_REQUEST     = 3'd2;
   localparam logic [2:0] OP_PHY_SENT    = 3'd3;
   localparam logic [2:0] OP_RETRY_FAIL  = 3'd4;
   localparam logic [2:0] OP_RP_STATUS   = 3'd5;

   // action codes
   localparam logic [2:0] ACT_RESET_PHY  = 3'd0;
   localparam logic [2:0] ACT_RESET_RX   = 3'd1;
   localparam logic [2:0] ACT_SEND       = 3'd2;
   localparam logic [2:0] ACT_TX_ERR     = 3'd3;
   localparam logic [2:0] ACT_TX_DONE    = 3'd4;

   // header message types and spec revision
   localparam logic [4:0] TYPE_GOODCRC    = 5'd1;
   localparam logic [4:0] TYPE_SOFT_RESET = 5'd13;
   localparam logic [1:0] REV_3_0         = 2'd2;
   localparam logic [1:0] REV_RESET       = 2'd1;

   // output queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one result transaction
   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] header;
      logic        last;
   } result_type;

   // results produced by one event, pushed into the queue together
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== rtl/core/usb_pd_protocol_tx_layer.sv =====
// usb power delivery protocol layer transmit machine, top level
// path: a transaction is captured in the input register, then pushed into the output
//   queue, whose head entry drives the result port; one event per cycle is taken while
//   the queue has room for two results, and results leave one per cycle unless stalled
// reset: synchronous active high; clears phase, pending flag, message id, queue;
//   spec revision returns to 1
module usb_pd_protocol_tx_layer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_msg_header,
   input  logic        req_starts_ams,
   input  logic        req_sink_tx_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [15:0] rsp_out_header,
   output logic        rsp_last
);
   import updtx_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [2:0]  op_ff;
   logic [15:0] hdr_ff;
   logic        ams_ff;
   logic        tx_ok_ff;
   logic [1:0]  spec_rev_ff;
   logic        load;
   logic        process;
   logic        room;
   push_type    push;

   // input register handshake
   assign process     = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign load        = req_valid && !req_stall;
   assign in_valid_in = load || (in_valid_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff    <= req_op;
         hdr_ff   <= req_msg_header;
         ams_ff   <= req_starts_ams;
         tx_ok_ff <= req_sink_tx_ok;
      end
   end

   // spec revision register
   always_ff @(posedge clock) begin
      if (reset) begin
         spec_rev_ff <= REV_RESET;
      end else if (csr_wr_en) begin
         spec_rev_ff <= csr_wr_data;
      end
   end

   updtx_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .process       (process),
      .op            (op_ff),
      .msg_header    (hdr_ff),
      .starts_ams    (ams_ff),
      .sink_tx_ok    (tx_ok_ff),
      .spec_revision (spec_rev_ff),
      .push          (push)
   );

   updtx_outq u_outq (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .room           (room),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_out_header (rsp_out_header),
      .rsp_last       (rsp_last)
   );

   // checks
   `include "usb_pd_protocol_tx_layer_assert.svh"

   `UPDTX_ASSERT_NOW(a_push_only_on_process, clock, reset, push.count != 2'd0, process, "results pushed without an event in process")
   `UPDTX_ASSERT_NOW(a_pair_marks_last, clock, reset, push.count == 2'd2, !push.first.last && push.second.last, "last flag misplaced in a result pair")
   `UPDTX_ASSERT_NEXT(a_pair_stays_together, clock, reset, rsp_valid && !rsp_last, rsp_valid, "second result of an event missing")

endmodule

// ===== rtl/core/updtx_engine.sv =====
// transmit state and per-event decode producing up to two results
module updtx_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 process,
   input  logic [2:0]           op,
   input  logic [15:0]          msg_header,
   input  logic                 starts_ams,
   input  logic                 sink_tx_ok,
   input  logic [1:0]           spec_revision,
   output updtx_pkg::push_type  push
);
   import updtx_pkg::*;

   // wait phases
   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_WAIT_RP  = 2'd1;
   localparam logic [1:0] PH_WAIT_PHY = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic        pending_ff, pending_in;
   logic [15:0] pend_hdr_ff, pend_hdr_in;
   logic [2:0]  msg_id_ff, msg_id_in;

   logic        idle;
   logic        soft_rst_msg;
   logic        good_crc;
   logic [2:0]  id_eff;
   logic [15:0] stamped;
   logic [1:0]  count;
   logic [2:0]  act0, act1;
   logic [15:0] hdr0, hdr1;

   // header decode
   assign idle         = !(phase_ff inside {PH_WAIT_RP, PH_WAIT_PHY});
   assign soft_rst_msg = (msg_header[4:0] == TYPE_SOFT_RESET) && (msg_header[14:12] == 3'd0);
   assign good_crc     = (msg_header[4:0] == TYPE_GOODCRC) && (msg_header[14:12] == 3'd0)
                         && (msg_header[11:9] == msg_id_ff);
   assign id_eff       = soft_rst_msg ? 3'd0 : msg_id_ff;
   assign stamped      = {msg_header[15:12], id_eff, msg_header[8:0]};

   // event decode and next state
   always_comb begin
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      pend_hdr_in = pend_hdr_ff;
      msg_id_in   = msg_id_ff;
      count       = 2'd0;
      act0        = ACT_RESET_PHY;
      act1        = ACT_RESET_PHY;
      hdr0        = 16'd0;
      hdr1        = 16'd0;
      case (op)
         OP_RESET, OP_DISCARD: begin
            if (op == OP_DISCARD && pending_ff) begin
               msg_id_in = msg_id_ff + 3'd1;
            end
            act0       = ACT_RESET_PHY;
            act1       = ACT_TX_ERR;
            count      = pending_ff ? 2'd2 : 2'd1;
            pending_in = 1'b0;
            phase_in   = PH_IDLE;
         end
         OP_REQUEST: begin
            if (idle) begin
               pending_in  = 1'b1;
               msg_id_in   = id_eff;
               pend_hdr_in = stamped;
               if (spec_revision == REV_3_0 && starts_ams) begin
                  phase_in = PH_WAIT_RP;
                  act0     = ACT_RESET_RX;
                  count    = soft_rst_msg ? 2'd1 : 2'd0;
               end else begin
                  phase_in = PH_WAIT_PHY;
                  if (soft_rst_msg) begin
                     act0  = ACT_RESET_RX;
                     act1  = ACT_SEND;
                     hdr1  = stamped;
                     count = 2'd2;
                  end else begin
                     act0  = ACT_SEND;
                     hdr0  = stamped;
                     count = 2'd1;
                  end
               end
            end
         end
         OP_PHY_SENT, OP_RETRY_FAIL: begin
            if (phase_ff == PH_WAIT_PHY) begin
               msg_id_in  = msg_id_ff + 3'd1;
               pending_in = 1'b0;
               phase_in   = PH_IDLE;
               act0       = (op == OP_PHY_SENT && good_crc) ? ACT_TX_DONE : ACT_TX_ERR;
               count      = 2'd1;
            end
         end
         OP_RP_STATUS: begin
            if (phase_ff == PH_WAIT_RP && sink_tx_ok) begin
               phase_in = PH_WAIT_PHY;
               act0     = ACT_SEND;
               hdr0     = pend_hdr_ff;
               count    = 2'd1;
            end
         end
         default: begin
            count = 2'd0;
         end
      endcase
   end

   // results handed to the output queue
   always_comb begin
      push.count         = process ? count : 2'd0;
      push.first.action  = act0;
      push.first.header  = hdr0;
      push.first.last    = (count == 2'd1);
      push.second.action = act1;
      push.second.header = hdr1;
      push.second.last   = 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pending_ff <= 1'b0;
         msg_id_ff  <= 3'd0;
      end else if (process) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         msg_id_ff  <= msg_id_in;
      end
   end

   // pending header, read only after written
   always_ff @(posedge clock) begin
      if (process) begin
         pend_hdr_ff <= pend_hdr_in;
      end
   end

endmodule

// ===== rtl/core/updtx_outq.sv =====
// small result queue taking up to two results per cycle while it has room, one out per cycle unless stalled
module updtx_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  updtx_pkg::push_type  push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_action,
   output logic [15:0]          rsp_out_header,
   output logic                 rsp_last
);
   import updtx_pkg::*;

   result_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QPTR_W-1:0]   wr_ptr_next;
   logic                pop;

   // handshake and space for a two-result push
   assign rsp_valid   = (count_ff != '0);
   assign pop         = rsp_valid && !rsp_stall;
   assign room        = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + QPTR_W'(1);

   // head entry drives the result transaction
   assign rsp_action     = entry_ff[rd_ptr_ff].action;
   assign rsp_out_header = entry_ff[rd_ptr_ff].header;
   assign rsp_last       = entry_ff[rd_ptr_ff].last;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule
